@@ rtl/core/per_pixel_median_stack_defines.svh @@
// ----------------------------------------------------------------------------
// Per-pixel median stack: assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef PER_PIXEL_MEDIAN_STACK_DEFINES_SVH
`define PER_PIXEL_MEDIAN_STACK_DEFINES_SVH

// same-cycle implication
`define PMS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pms: same-cycle check failed");

// next-cycle implication
`define PMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pms: next-cycle check failed");

`endif

@@ rtl/core/pms_pkg.sv @@
// ----------------------------------------------------------------------------
// pms_pkg
// Types and fixed widths shared by the median stack controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

	localparam int SAMPLE_W = 24;  // Q20.4
	localparam int MEDIAN_W = 25;  // Q20.5
	localparam int USED_W   = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_MRD0,
		ST_MRD1,
		ST_MOUT
	} pms_state_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_IN,     // new sample into empty store
		WR_SHIFT,  // move entry down one slot
		WR_KEY     // drop key into its slot
	} pms_wr_sel_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_LOAD,   // entry count-1 on accept
		RD_SHIFT,  // entry pos-2 while shifting
		RD_MED_A,  // median operand at the lower address
		RD_MED_B   // median operand at the upper address
	} pms_rd_sel_t;

	typedef struct packed {
		logic        load;
		pms_wr_sel_t wr_sel;
		pms_rd_sel_t rd_sel;
		logic        pos_dec;
		logic        lo_cap;
		logic        out_load;
	} pms_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic prev_less;
		logic pos_one;
		logic last;
		logic out_free;
	} pms_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pms_datapath.sv @@
// ----------------------------------------------------------------------------
// pms_datapath
// Sorted sample store, insertion pointer, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_datapath #(
	parameter int MAX_FRAMES = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic signed [pms_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                                  last_sample,
	input  wire pms_pkg::pms_cmd_t                     cmd,
	output pms_pkg::pms_stat_t                         stat,
	output logic signed [pms_pkg::MEDIAN_W-1:0]        median_value,
	output logic [pms_pkg::USED_W-1:0]                 samples_used,
	output logic                                       overflowed,
	output logic                                       result_valid,
	input  wire logic                                  result_ready
);

	localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int SW    = pms_pkg::SAMPLE_W;

	logic [SW-1:0]    store_mem [0:MAX_FRAMES-1];
	logic [SW-1:0]    rdata_q;
	logic [SW-1:0]    key_q;
	logic [SW-1:0]    lo_q;
	logic [AW-1:0]    pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             last_q;
	logic             out_valid_q;

	logic [pms_pkg::MEDIAN_W-1:0] median_q;
	logic [pms_pkg::USED_W-1:0]   used_q;
	logic                         ovf_out_q;

	logic [CNT_W-1:0] half;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [SW-1:0]    wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             full;

	assign full = (cnt_q >= CNT_W'(MAX_FRAMES));
	assign half = cnt_q >> 1;

	// write port
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = pos_q;
		wr_data = key_q;
		case (cmd.wr_sel)
			pms_pkg::WR_IN: begin
				wr_addr = '0;
				wr_data = sample;
			end
			pms_pkg::WR_SHIFT: begin
				wr_data = rdata_q;
			end
			pms_pkg::WR_KEY: begin
				wr_data = key_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// read port
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		case (cmd.rd_sel)
			pms_pkg::RD_LOAD:  rd_addr = AW'(cnt_q - CNT_W'(1));
			pms_pkg::RD_SHIFT: rd_addr = pos_q - AW'(2);
			pms_pkg::RD_MED_A: rd_addr = cnt_q[0] ? AW'(half) : AW'(half - CNT_W'(1));
			pms_pkg::RD_MED_B: rd_addr = AW'(half);
			default:           rd_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= sample;
			pos_q <= AW'(cnt_q);
		end else if (cmd.pos_dec) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.lo_cap) begin
			lo_q <= rdata_q;
		end
		if (cmd.out_load) begin
			// odd count reads the middle twice, so the sum is the doubled value
			median_q  <= {lo_q[SW-1], lo_q} + {rdata_q[SW-1], rdata_q};
			used_q    <= pms_pkg::USED_W'(cnt_q);
			ovf_out_q <= ovf_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q <= last_sample;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.out_load) begin
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.full      = full;
		stat.empty     = (cnt_q == '0);
		stat.prev_less = ($signed(rdata_q) < $signed(key_q));
		stat.pos_one   = (pos_q == AW'(1));
		stat.last      = last_q;
		stat.out_free  = !out_valid_q || result_ready;
	end

	assign median_value = $signed(median_q);
	assign samples_used = used_q;
	assign overflowed   = ovf_out_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/pms_ctrl.sv @@
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer for insertion, median read-out and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	input  wire logic               last_sample,
	output logic                    sample_ready,
	input  wire pms_pkg::pms_stat_t stat,
	output pms_pkg::pms_cmd_t       cmd
);

	pms_pkg::pms_state_t state_q;
	pms_pkg::pms_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		cmd.load     = 1'b0;
		cmd.wr_sel   = pms_pkg::WR_NONE;
		cmd.rd_sel   = pms_pkg::RD_NONE;
		cmd.pos_dec  = 1'b0;
		cmd.lo_cap   = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			pms_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					if (stat.full) begin
						if (last_sample) state_d = pms_pkg::ST_MRD0;
					end else if (stat.empty) begin
						cmd.wr_sel = pms_pkg::WR_IN;
						if (last_sample) state_d = pms_pkg::ST_MRD0;
					end else begin
						cmd.rd_sel = pms_pkg::RD_LOAD;
						state_d    = pms_pkg::ST_SHIFT;
					end
				end
			end
			pms_pkg::ST_SHIFT: begin
				if (stat.prev_less) begin
					cmd.wr_sel  = pms_pkg::WR_SHIFT;
					cmd.pos_dec = 1'b1;
					if (stat.pos_one) begin
						state_d = pms_pkg::ST_PLACE;
					end else begin
						cmd.rd_sel = pms_pkg::RD_SHIFT;
					end
				end else begin
					cmd.wr_sel = pms_pkg::WR_KEY;
					state_d    = stat.last ? pms_pkg::ST_MRD0 : pms_pkg::ST_IDLE;
				end
			end
			pms_pkg::ST_PLACE: begin
				cmd.wr_sel = pms_pkg::WR_KEY;
				state_d    = stat.last ? pms_pkg::ST_MRD0 : pms_pkg::ST_IDLE;
			end
			pms_pkg::ST_MRD0: begin
				cmd.rd_sel = pms_pkg::RD_MED_A;
				state_d    = pms_pkg::ST_MRD1;
			end
			pms_pkg::ST_MRD1: begin
				cmd.lo_cap = 1'b1;
				cmd.rd_sel = pms_pkg::RD_MED_B;
				state_d    = pms_pkg::ST_MOUT;
			end
			pms_pkg::ST_MOUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = pms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pms_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/per_pixel_median_stack.sv @@
// ----------------------------------------------------------------------------
// per_pixel_median_stack
// Median of one pixel's samples over a frame stack, kept sorted by insertion.
// ----------------------------------------------------------------------------
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  --------------------------
//  in        sample[23:0], last_sample                    sample_valid / sample_ready
//  out       median_value[24:0], samples_used, overflowed result_valid / result_ready
//
//  A request with the store empty or full needs no shifting; otherwise each
//  stored entry below the sample moves one slot on (one shift per cycle),
//  then the sample is placed. A last request adds the median read-out
//  (ST_MRD0, ST_MRD1, ST_MOUT); if the previous result still waits for
//  result_ready, ST_MOUT holds and new requests stall. Reset is asynchronous;
//  the store is not cleared, since only written entries are ever read.
//
`default_nettype none

module per_pixel_median_stack #(
	parameter int MAX_FRAMES = 32  // store depth, 1..63
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [pms_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                last_sample,
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	output logic signed [pms_pkg::MEDIAN_W-1:0]      median_value,
	output logic [pms_pkg::USED_W-1:0]               samples_used,
	output logic                                     overflowed,
	output logic                                     result_valid,
	input  wire logic                                result_ready
);

	`include "per_pixel_median_stack_defines.svh"

	pms_pkg::pms_cmd_t  cmd;
	pms_pkg::pms_stat_t stat;

	// sequencer: accepts requests, walks the insertion, reads the median
	pms_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.last_sample  (last_sample),
		.sample_ready (sample_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// store, pointers, median adder and result register
	pms_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.last_sample  (last_sample),
		.cmd          (cmd),
		.stat         (stat),
		.median_value (median_value),
		.samples_used (samples_used),
		.overflowed   (overflowed),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	// a new result never overwrites one that is still waiting
	`PMS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !result_valid || result_ready)

	// a last request always holds off the next one while the median is read
	`PMS_ASSERT_NEXT(a_last_blocks, sample_valid && sample_ready && last_sample, !sample_ready)

	// the pointer steps down exactly when an entry is shifted within the store
	`PMS_ASSERT_SAME(a_dec_on_shift, cmd.pos_dec, cmd.wr_sel == pms_pkg::WR_SHIFT)

endmodule

`default_nettype wire
